// File: src/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and constants of the page table walker
// Status codes, masks and the transaction structs that pass between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

   localparam int unsigned ADDR_W   = 64;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned LEVEL_W  = 3;
   localparam int unsigned IDX_W    = 9;

   localparam logic [STATUS_W-1:0] STATUS_READ       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNEXPECTED = 2'd3;

   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_RESPONSE  = 1'b1;

   localparam logic [ADDR_W-1:0] TABLE_MASK  = 64'h7FFF_FFFF_FFFF_FF00;
   localparam logic [ADDR_W-1:0] PAGE_MASK   = 64'h7FFF_FFFF_FFFF_F000;
   localparam logic [ADDR_W-1:0] ALIGN_MASK  = 64'hFFFF_FFFF_FFFF_FFF8;
   localparam logic [ADDR_W-1:0] ADDR_LIMIT  = 64'h0FFF_FFFF_FFFF_FFFF;
   localparam logic [ADDR_W-1:0] OFFSET_MASK = 64'h0000_0000_0000_0FFF;

   typedef struct packed {
      logic              op;
      logic [ADDR_W-1:0] virtual_address;
      logic [ADDR_W-1:0] read_data;
   } walk_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   address;
      logic [LEVEL_W-1:0]  level;
   } walk_result_type;

endpackage

`default_nettype wire

// File: src/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker: four-level page table walker
// Input register, combinational walk step and result register, one transaction
// per clock while the consumer takes responses.
// ----------------------------------------------------------------------------
// A translate transaction carrying a virtual address starts a walk: the block
// answers with a read request for the top-level entry at root_table_base plus
// VA[47:39] times 8. Each table entry that memory returns is sent back in as a
// response transaction; the block masks it to the next table base and asks for
// the next level, and after the fourth entry it returns the physical address
// (page frame plus VA[11:0]). Every request transaction produces exactly one
// response transaction: a read request, the finished translation, an
// out-of-range abort (read address above 0x0FFFFFFFFFFFFFFF, walk abandoned)
// or an unexpected-transaction flag (translate while a walk is running, or a
// table entry while idle). Present bits and large pages are not checked. The
// block takes one transaction every clock while responses are taken, with the
// 64-bit index add and range compare of the single step stage setting the
// clock rate. Write root_table_base only while no walk is in flight and all
// responses have been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_walker
   import ptw_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                csr_write_enable,
   input  wire logic [ADDR_W-1:0]   csr_write_data,

   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_op,
   input  wire logic [ADDR_W-1:0]   req_virtual_address,
   input  wire logic [ADDR_W-1:0]   req_read_data,

   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ADDR_W-1:0]        rsp_address,
   output logic [LEVEL_W-1:0]       rsp_level
);

   // Root table base, the one configuration register.
   logic [ADDR_W-1:0] root_table_base_ff, root_table_base_in;

   logic            item_valid;
   walk_item_type   item;
   logic            out_space;
   logic            step_fire;
   walk_result_type step_result;
   logic            walk_busy;

   assign root_table_base_in = csr_write_enable ? csr_write_data : root_table_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_table_base_ff <= '0;
      end else begin
         root_table_base_ff <= root_table_base_in;
      end
   end

   // A held transaction moves through the step logic whenever the result
   // register has room, which is also what frees the input register.
   assign step_fire = item_valid && out_space;

   ptw_in_reg u_in_reg (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_virtual_address (req_virtual_address),
      .req_read_data       (req_read_data),
      .take                (step_fire),
      .item_valid          (item_valid),
      .item                (item)
   );

   // Walk state only advances on the cycle a transaction is stepped, so the
   // next transaction always sees the state this one leaves behind.
   ptw_walk_core u_walk_core (
      .clock           (clock),
      .reset           (reset),
      .step            (step_fire),
      .item            (item),
      .root_table_base (root_table_base_ff),
      .result          (step_result),
      .busy            (walk_busy)
   );

   ptw_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (step_fire),
      .result      (step_result),
      .space       (out_space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_address (rsp_address),
      .rsp_level   (rsp_level)
   );

   // A full input register can only accept while its content moves on.
   a_in_reg_no_overwrite: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && req_ready && item_valid) |-> step_fire
   ) else $error("input register overwritten before its transaction was stepped");

   // Issuing a read request leaves a walk in flight.
   a_read_sets_busy: assert property (
      @(posedge clock) disable iff (reset)
      (step_fire && step_result.status == STATUS_READ) |=> walk_busy
   ) else $error("read request issued without entering the busy state");

   // Finishing or aborting a walk returns to idle.
   a_end_clears_busy: assert property (
      @(posedge clock) disable iff (reset)
      (step_fire && (step_result.status == STATUS_DONE ||
                     step_result.status == STATUS_RANGE)) |=> !walk_busy
   ) else $error("walk did not return to idle after completion or abort");

   // Read requests carry a table level and an aligned, in-range address.
   a_read_shape: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_READ) |->
         (rsp_level != 3'd0 && rsp_address[2:0] == 3'd0 && rsp_address[63:60] == 4'd0)
   ) else $error("malformed read request");

endmodule

`default_nettype wire

// File: src/ptw_in_reg.sv
// ----------------------------------------------------------------------------
// ptw_in_reg: input register of the page table walker
// Captures one request transaction and holds it until the step logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_in_reg
   import ptw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_op,
   input  wire logic [ADDR_W-1:0] req_virtual_address,
   input  wire logic [ADDR_W-1:0] req_read_data,
   input  wire logic              take,
   output logic                   item_valid,
   output walk_item_type          item
);

   logic          valid_ff, valid_in;
   walk_item_type item_ff;
   logic          accept;

   // The register may refill in the same cycle that its content moves on.
   assign req_ready = !valid_ff || take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.op              <= req_op;
         item_ff.virtual_address <= req_virtual_address;
         item_ff.read_data       <= req_read_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// File: src/ptw_walk_core.sv
// ----------------------------------------------------------------------------
// ptw_walk_core: walk state and combinational step logic
// Holds the walk state and turns one transaction into one result.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_walk_core
   import ptw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  walk_item_type          item,
   input  wire logic [ADDR_W-1:0] root_table_base,
   output walk_result_type        result,
   output logic                   busy
);

   logic              busy_ff, busy_in;
   logic [1:0]        level_ff, level_in;
   logic [ADDR_W-1:0] saved_va_ff, saved_va_in;

   logic              do_issue;
   logic [1:0]        issue_sel;
   logic [ADDR_W-1:0] issue_base;
   logic [ADDR_W-1:0] issue_va;
   logic [IDX_W-1:0]  index;
   logic [ADDR_W-1:0] read_addr;

   always_comb begin
      do_issue    = 1'b0;
      issue_sel   = 2'd0;
      issue_base  = root_table_base;
      issue_va    = saved_va_ff;
      busy_in     = busy_ff;
      level_in    = level_ff;
      saved_va_in = saved_va_ff;
      result      = '{status: STATUS_UNEXPECTED, address: '0, level: '0};

      if (item.op == OP_TRANSLATE) begin
         if (!busy_ff) begin
            do_issue    = 1'b1;
            issue_va    = item.virtual_address;
            saved_va_in = item.virtual_address;
         end
      end else if (busy_ff) begin
         if (level_ff != 2'd3) begin
            do_issue   = 1'b1;
            issue_sel  = level_ff + 2'd1;
            issue_base = item.read_data & TABLE_MASK;
         end else begin
            busy_in  = 1'b0;
            level_in = 2'd0;
            result.status  = STATUS_DONE;
            result.address = (item.read_data & PAGE_MASK) + (saved_va_ff & OFFSET_MASK);
         end
      end

      // Each level consumes the next nine address bits, top down.
      unique case (issue_sel)
         2'd0:    index = issue_va[47:39];
         2'd1:    index = issue_va[38:30];
         2'd2:    index = issue_va[29:21];
         2'd3:    index = issue_va[20:12];
         default: index = issue_va[47:39];
      endcase

      read_addr = (issue_base + {{(ADDR_W-IDX_W-3){1'b0}}, index, 3'b000}) & ALIGN_MASK;

      if (do_issue) begin
         if (read_addr > ADDR_LIMIT) begin
            busy_in  = 1'b0;
            level_in = 2'd0;
            result   = '{status: STATUS_RANGE, address: read_addr, level: '0};
         end else begin
            busy_in  = 1'b1;
            level_in = issue_sel;
            result   = '{status: STATUS_READ, address: read_addr,
                         level: {1'b0, issue_sel} + 3'd1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         level_ff    <= 2'd0;
         saved_va_ff <= '0;
      end else if (step) begin
         busy_ff     <= busy_in;
         level_ff    <= level_in;
         saved_va_ff <= saved_va_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// File: src/ptw_out_reg.sv
// ----------------------------------------------------------------------------
// ptw_out_reg: result register of the page table walker
// Holds one response transaction until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_out_reg
   import ptw_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  walk_result_type          result,
   output logic                     space,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ADDR_W-1:0]        rsp_address,
   output logic [LEVEL_W-1:0]       rsp_level
);

   logic            valid_ff, valid_in;
   walk_result_type result_ff;

   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_status  = result_ff.status;
   assign rsp_address = result_ff.address;
   assign rsp_level   = result_ff.level;

endmodule

`default_nettype wire

// File: tb/sv/four_level_page_table_walker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_tb: self-checking testbench of the walker
// Drives translate and table-entry transactions through the request channel,
// predicts every response with a cycle-free model of the walk, and compares
// each accepted response field by field. The root table base is reprogrammed
// between phases, and both channels idle and stall at random.
// ----------------------------------------------------------------------------

module four_level_page_table_walker_tb;

   import ptw_pkg::*;

   localparam int CLK_HALF       = 6;
   localparam int RESET_CYCLES   = 11;
   localparam int STALL_LIMIT    = 3000;  // cycles without any transaction
   localparam int SETTLE_CYCLES  = 8;     // margin for stray responses after the drain
   localparam int MAX_PRINTED    = 40;
   localparam int PHASE_ITEMS    = 150;
   localparam int CHUNK_ITEMS    = 50;

   // Clock, reset and all block inputs start at known values.
   logic                 clock;
   logic                 reset               = 1'b1;
   logic                 csr_write_enable    = 1'b0;
   logic [ADDR_W-1:0]    csr_write_data      = '0;
   logic                 req_valid           = 1'b0;
   logic                 req_ready;
   logic                 req_op              = OP_TRANSLATE;
   logic [ADDR_W-1:0]    req_virtual_address = '0;
   logic [ADDR_W-1:0]    req_read_data       = '0;
   logic                 rsp_valid;
   logic                 rsp_ready           = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [ADDR_W-1:0]    rsp_address;
   logic [LEVEL_W-1:0]   rsp_level;

   // Shared control between the test tasks and the response sink.
   bit jitter_on        = 1'b1;  // random gaps on both channels
   int rsp_hold_cycles  = 0;     // a long receiver hold-off, when nonzero
   int error_count      = 0;
   int idle_cycles      = 0;

   // Mirror of the walker's architectural state, advanced at each accepted
   // request transaction.
   logic [ADDR_W-1:0] model_root_base = '0;
   logic              model_busy      = 1'b0;
   logic [1:0]        model_level     = '0;
   logic [ADDR_W-1:0] model_va        = '0;

   // Responses the walker still owes, oldest first.
   walk_result_type pending_walk_results[$];

   four_level_page_table_walker dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_virtual_address (req_virtual_address),
      .req_read_data       (req_read_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_address         (rsp_address),
      .rsp_level           (rsp_level)
   );

   always begin
      clock = 1'b0;
      #CLK_HALF;
      clock = 1'b1;
      #CLK_HALF;
   end

   // -------------------------------------------------------------------------
   // Walk prediction
   // -------------------------------------------------------------------------

   // Builds the read request for table level lvl (1 to 4) whose table starts at
   // base. The index is the 9-bit slice of the saved address for that level,
   // and the sum wraps at 64 bits before it is aligned down to 8 bytes. An
   // aligned address past the physical limit abandons the walk.
   function automatic walk_result_type table_read(input logic [ADDR_W-1:0] base,
                                                  input int unsigned lvl);
      walk_result_type   r;
      int unsigned       shift;
      logic [ADDR_W-1:0] index;
      logic [ADDR_W-1:0] entry_addr;
      shift      = 39 - 9 * (lvl - 1);
      index      = (model_va >> shift) & 64'h1FF;
      entry_addr = (base + (index << 3)) & ALIGN_MASK;
      if (entry_addr > ADDR_LIMIT) begin
         model_busy  = 1'b0;
         model_level = '0;
         r.status    = STATUS_RANGE;
         r.address   = entry_addr;
         r.level     = '0;
      end else begin
         model_busy  = 1'b1;
         model_level = 2'(lvl - 1);
         r.status    = STATUS_READ;
         r.address   = entry_addr;
         r.level     = LEVEL_W'(lvl);
      end
      return r;
   endfunction

   // Advances the mirror by one accepted request transaction and returns the
   // response the walker must produce for it.
   function automatic walk_result_type predict_walk_step(input logic op,
                                                         input logic [ADDR_W-1:0] va,
                                                         input logic [ADDR_W-1:0] rd);
      walk_result_type r;
      r = '{status: STATUS_UNEXPECTED, address: '0, level: '0};
      if (op == OP_TRANSLATE) begin
         // A translate during a walk is flagged and leaves the walk alone.
         if (!model_busy) begin
            model_va = va;
            r = table_read(model_root_base, 1);
         end
      end else if (model_busy) begin
         if (model_level < 2'd3) begin
            r = table_read(rd & TABLE_MASK, model_level + 2);
         end else begin
            model_busy  = 1'b0;
            model_level = '0;
            r.status    = STATUS_DONE;
            r.address   = (rd & PAGE_MASK) + (model_va & OFFSET_MASK);
            r.level     = '0;
         end
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Shared helpers
   // -------------------------------------------------------------------------

   task automatic report_error(input string msg);
      if (error_count < MAX_PRINTED)
         $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   // Offers one request transaction and waits for its acceptance. Valid is
   // left high afterwards so that a back-to-back transaction follows without
   // a bubble; a gap, if any, lowers it at the start of the next call.
   task automatic issue_transaction(input logic op,
                                    input logic [ADDR_W-1:0] va,
                                    input logic [ADDR_W-1:0] rd);
      int gap;
      gap = (jitter_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_op              <= op;
      req_virtual_address <= va;
      req_read_data       <= rd;
      do @(posedge clock); while (!(req_valid && req_ready));
      pending_walk_results.push_back(predict_walk_step(op, va, rd));
   endtask

   task automatic translate(input logic [ADDR_W-1:0] va);
      issue_transaction(OP_TRANSLATE, va, {$urandom, $urandom});
   endtask

   task automatic return_entry(input logic [ADDR_W-1:0] rd);
      issue_transaction(OP_RESPONSE, {$urandom, $urandom}, rd);
   endtask

   // Stops offering and waits until every owed response has been taken. It
   // always waits on the clock before it returns, so the caller may drive again.
   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_walk_results.size() != 0);
   endtask

   // The root base may only change while the walker is idle and drained.
   task automatic write_root(input logic [ADDR_W-1:0] value);
      wait_all_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_root_base   = value;
   endtask

   // Table entry that usually keeps the next read in range. Bit 63 stays
   // random since the table mask drops it anyway.
   function automatic logic [ADDR_W-1:0] random_entry();
      logic [ADDR_W-1:0] rd;
      rd = {$urandom, $urandom};
      if ($urandom_range(0, 4) != 0)
         rd[62:56] = '0;
      return rd;
   endfunction

   // -------------------------------------------------------------------------
   // Response sink: random stalls, plus a long hold-off on request.
   // -------------------------------------------------------------------------
   initial begin : response_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b1;
         end else if (jitter_on && $urandom_range(0, 3) == 0) begin
            stall = pick_gap();
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response checker: each accepted response against the oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      walk_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_walk_results.size() == 0) begin
            report_error($sformatf("response with nothing owed: status %0d address %h",
                                   rsp_status, rsp_address));
         end else begin
            want = pending_walk_results.pop_front();
            if (rsp_status !== want.status)
               report_error($sformatf("status %0d, predicted %0d", rsp_status, want.status));
            if (rsp_address !== want.address)
               report_error($sformatf("address %h, predicted %h", rsp_address, want.address));
            if (rsp_level !== want.level)
               report_error($sformatf("level %0d, predicted %0d", rsp_level, want.level));
         end
      end
   end

   // Watchdog: a hung handshake on either channel ends the run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // A full walk with the reset root base and all-zero tables. Every read
   // lands at address zero and the page offset is zero as well.
   task automatic test_reset_walk();
      translate('0);
      repeat (4) return_entry('0);
   endtask

   // All index slices at their maximum and entries whose masked-off bits are
   // set: bit 63 and the low byte must be dropped. The third entry masks to a
   // table past the limit, so the last read aborts and the fourth entry is flagged.
   task automatic test_full_walk_extremes();
      write_root(64'h0000_0000_0010_0000);
      translate('1);
      return_entry(64'h8000_0000_0012_34FF);
      return_entry(64'h8000_0000_0056_78FF);
      return_entry(64'hFFF0_0000_009A_BCFF);
      return_entry('1);
   endtask

   // An all-ones entry masks to a table far past the limit, so the second level
   // read aborts the walk; a second walk reads a table just under the limit, then aborts at its third level.
   task automatic test_range_abort();
      translate('1);
      return_entry('1);
      translate(64'h0000_0000_0000_0ABC);
      return_entry(64'h0FFF_FFFF_FFFF_F0FF);
      return_entry(64'h1000_0000_0000_0000);
   endtask

   // A table entry while idle and a translate in the middle of a walk are
   // both flagged; the interrupted walk must then finish normally.
   task automatic test_unexpected_items();
      return_entry('1);
      translate(64'h0000_7FC0_2010_0123);
      translate('1);
      return_entry(64'h0000_0000_0001_0000);
      return_entry(64'h0000_0000_0002_0000);
      return_entry(64'h0000_0000_0003_0000);
      return_entry(64'h0000_0012_3456_7000);
   endtask

   // Root base at the top of the address space: index zero gives an aligned
   // address past the limit, while index one wraps around to zero. A root
   // just under the limit is aligned down and stays legal only for index zero.
   task automatic test_root_extremes();
      write_root('1);
      translate('0);
      translate(64'h0000_0080_0000_0FFF);
      repeat (4) return_entry('0);
      write_root(ADDR_LIMIT);
      translate('0);
      return_entry(ADDR_LIMIT);
      return_entry(64'h1000_0000_0000_0000);
      translate(64'h0000_0080_0000_0000);
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering back-to-back walks, so the walker fills and stalls its input.
   // The sender then pauses until every owed response has drained.
   task automatic test_backpressure();
      int n;
      write_root(64'h0000_0000_0200_0000);
      jitter_on       = 1'b0;
      rsp_hold_cycles = 200;
      for (n = 0; n < 6; n++) begin
         translate({$urandom, $urandom});
         repeat (4) return_entry(random_entry() & 64'h00FF_FFFF_FFFF_FFFF);
      end
      wait_all_results();
      jitter_on = 1'b1;
   endtask

   // Mostly well-formed walks with random content; the rest are stray
   // entries while idle and stray translates during a walk.
   task automatic random_item();
      if (!model_busy) begin
         if ($urandom_range(0, 9) != 0)
            translate({$urandom, $urandom});
         else
            return_entry({$urandom, $urandom});
      end else begin
         if ($urandom_range(0, 11) != 0)
            return_entry(random_entry());
         else
            translate({$urandom, $urandom});
      end
   endtask

   // Random walks under several root bases, the extremes among them, with
   // stretches of idling and stretches of full-rate traffic.
   task automatic test_random_walks();
      logic [ADDR_W-1:0] root;
      int                phase;
      int                n;
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0, 5: begin
               root = {$urandom, $urandom} & 64'h00FF_FFFF_FFFF_FFFF;
            end
            1: begin
               root = '0;
            end
            2: begin
               root = 64'h0FFF_FFFF_FFFF_F000;
            end
            3: begin
               root = {$urandom, $urandom} & 64'h0000_0000_FFFF_FFFF;
            end
            default: begin
               root = '1;
            end
         endcase
         write_root(root);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % CHUNK_ITEMS == 0)
               jitter_on = ($urandom_range(0, 3) != 0);
            random_item();
         end
      end
      jitter_on = 1'b1;
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_walk();
      test_full_walk_extremes();
      test_range_abort();
      test_unexpected_items();
      test_root_extremes();
      test_backpressure();
      test_random_walks();

      // Drain, then give any stray response time to show up.
      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: files.f
src/ptw_pkg.sv
src/ptw_in_reg.sv
src/ptw_walk_core.sv
src/ptw_out_reg.sv
src/four_level_page_table_walker.sv
tb/sv/four_level_page_table_walker_tb.sv
